[src/rc5_pkg.sv]
// rc5_pkg: shared constants, command/status types and rotate helpers for the
// rc5 cbc cipher block. Used by rc5_ctrl, rc5_dp and rc5_cbc_block_cipher.
// No dependencies.
`default_nettype none

package rc5_pkg;

   // default cipher configuration
   localparam int RC5_ROUNDS  = 12;
   localparam int WORD_W      = 32;
   localparam int BLOCK_W     = 64;
   localparam int ROT_W       = 5;
   localparam int KEY_WORDS   = 4;
   localparam int KW_IDX_W    = 2;

   // csr port geometry
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   // key schedule magic constants
   localparam logic [WORD_W-1:0] MAGIC_P   = 32'hB7E15163;
   localparam logic [WORD_W-1:0] MAGIC_Q   = 32'h9E3779B9;
   localparam logic [ROT_W-1:0]  SCHED_ROT = 5'd3;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_LOW     = 2'd0,
      CSR_KEY_HIGH    = 2'd1,
      CSR_INIT_VECTOR = 2'd2,
      CSR_DIRECTION   = 2'd3
   } csr_index_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCHED_INIT,
      OP_SCHED_STEP,
      OP_KEY_ADD,
      OP_ENC_ROUND,
      OP_DEC_ROUND,
      OP_KEY_SUB
   } dp_op_type;

   // controller to datapath
   typedef struct packed {
      dp_op_type op;
      logic      first_pass;
      logic      deliver_step;
      logic      deliver_held;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cfg_kick;
      logic decrypt;
      logic out_free;
   } dp_status_type;

   // rotate left by amount mod 32
   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                input logic [ROT_W-1:0] s);
      logic [2*WORD_W-1:0] dbl;
      dbl = {x, x} << s;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

   // rotate right by amount mod 32
   function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                                input logic [ROT_W-1:0] s);
      logic [2*WORD_W-1:0] dbl;
      dbl = {x, x} >> s;
      return dbl[WORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

[src/rc5_ctrl.sv]
// rc5_ctrl: sequencer for the key schedule and the cipher rounds; drives the
// datapath command, round key addresses and the input handshake.
// Depends on rc5_pkg.
`default_nettype none

module rc5_ctrl #(
   parameter int ROUNDS = rc5_pkg::RC5_ROUNDS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire rc5_pkg::dp_status_type status,
   output rc5_pkg::dp_cmd_type        cmd,
   output logic [$clog2(ROUNDS+1)-1:0] key_rd_addr,
   output logic [$clog2(ROUNDS+1):0]   key_wr_index
);

   localparam int AW          = $clog2(ROUNDS + 1);
   localparam int IW          = AW + 1;
   localparam int NKEYS       = 2 * ROUNDS + 2;
   localparam int SCHED_STEPS = 3 * NKEYS;
   localparam int SW          = $clog2(SCHED_STEPS);

   localparam logic [SW-1:0] SCHED_LAST = SW'(SCHED_STEPS - 1);
   localparam logic [SW-1:0] ROUND_LAST = SW'(ROUNDS);
   localparam logic [SW-1:0] FIRST_REV  = SW'(ROUNDS - 1);
   localparam logic [SW-1:0] NKEYS_SW   = SW'(NKEYS);
   localparam logic [IW-1:0] IDX_LAST   = IW'(NKEYS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCHED,
      ST_CRYPT,
      ST_HOLD
   } state_type;

   state_type     state_ff;
   logic [SW-1:0] step_ff;
   logic [IW-1:0] idx_ff;
   logic [IW-1:0] idx_next;
   logic [AW-1:0] first_addr;
   logic          accept;
   logic          round_last;

   assign idx_next   = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
   assign first_addr = status.decrypt ? AW'(ROUNDS) : '0;
   assign round_last = (step_ff == ROUND_LAST);

   // input handshake: only between blocks and never on a key/iv write
   assign req_tready = (state_ff == ST_IDLE) && !status.cfg_kick;
   assign accept     = req_tvalid && req_tready;

   // state, round and schedule counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         idx_ff   <= '0;
      end else if (status.cfg_kick) begin
         state_ff <= ST_INIT;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_CRYPT;
                  step_ff  <= '0;
               end
            end
            ST_INIT: begin
               state_ff <= ST_SCHED;
               step_ff  <= '0;
               idx_ff   <= '0;
            end
            ST_SCHED: begin
               idx_ff <= idx_next;
               if (step_ff == SCHED_LAST) begin
                  state_ff <= ST_IDLE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_CRYPT: begin
               if (round_last) begin
                  state_ff <= status.out_free ? ST_IDLE : ST_HOLD;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_HOLD: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // datapath command decode
   always_comb begin
      cmd = '{op: rc5_pkg::OP_NONE, first_pass: 1'b0,
              deliver_step: 1'b0, deliver_held: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.op = rc5_pkg::OP_LOAD;
            end
         end
         ST_INIT: begin
            cmd.op = rc5_pkg::OP_SCHED_INIT;
         end
         ST_SCHED: begin
            cmd.op         = rc5_pkg::OP_SCHED_STEP;
            cmd.first_pass = (step_ff < NKEYS_SW);
         end
         ST_CRYPT: begin
            if (status.decrypt) begin
               cmd.op = round_last ? rc5_pkg::OP_KEY_SUB : rc5_pkg::OP_DEC_ROUND;
            end else begin
               cmd.op = (step_ff == '0) ? rc5_pkg::OP_KEY_ADD : rc5_pkg::OP_ENC_ROUND;
            end
            cmd.deliver_step = round_last && status.out_free;
         end
         ST_HOLD: begin
            cmd.deliver_held = status.out_free;
         end
         default: begin
            cmd.op = rc5_pkg::OP_NONE;
         end
      endcase
   end

   // round key prefetch address, issued in the cycle before the key is used
   always_comb begin
      if (state_ff == ST_SCHED) begin
         key_rd_addr = idx_next[IW-1:1];
      end else if ((state_ff == ST_CRYPT) && !round_last) begin
         key_rd_addr = status.decrypt ? AW'(FIRST_REV - step_ff) : AW'(step_ff + 1'b1);
      end else begin
         key_rd_addr = first_addr;
      end
   end

   assign key_wr_index = idx_ff;

   // an accepted block always starts at round step zero
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CRYPT) && (step_ff == '0))
      else $error("block did not start its rounds after acceptance");

   // round counter never passes the final key step
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRYPT) |-> (step_ff <= ROUND_LAST))
      else $error("round counter overran");

   // schedule index stays inside the round key table
   a_sched_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCHED) |-> (idx_ff <= IDX_LAST))
      else $error("schedule index overran");

endmodule

`default_nettype wire

[src/rc5_dp.sv]
// rc5_dp: csr registers, round key memory, key schedule and round datapath,
// cbc chain and result register. Commanded by rc5_ctrl.
// Depends on rc5_pkg.
`default_nettype none

module rc5_dp #(
   parameter int ROUNDS = rc5_pkg::RC5_ROUNDS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [rc5_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [rc5_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic [rc5_pkg::BLOCK_W-1:0]          req_tdata,
   input  wire logic                                 req_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [rc5_pkg::BLOCK_W-1:0]               rsp_tdata,
   output logic                                      rsp_tlast,
   input  wire rc5_pkg::dp_cmd_type                  cmd,
   input  wire logic [$clog2(ROUNDS+1)-1:0]          key_rd_addr,
   input  wire logic [$clog2(ROUNDS+1):0]            key_wr_index,
   output rc5_pkg::dp_status_type                    status
);

   localparam int AW    = $clog2(ROUNDS + 1);
   localparam int IW    = AW + 1;
   localparam int DEPTH = ROUNDS + 1;
   localparam int W     = rc5_pkg::WORD_W;

   // configuration and chain
   logic [rc5_pkg::CSR_DATA_W-1:0] key_low_ff;
   logic [rc5_pkg::CSR_DATA_W-1:0] key_high_ff;
   logic [rc5_pkg::BLOCK_W-1:0]    iv_ff;
   logic                           decrypt_ff;
   logic [rc5_pkg::BLOCK_W-1:0]    chain_ff;

   // working words
   logic [W-1:0]                   a_ff;
   logic [W-1:0]                   b_ff;
   logic [W-1:0]                   acc_ff;
   logic [W-1:0]                   lw_ff [rc5_pkg::KEY_WORDS];
   logic [rc5_pkg::KW_IDX_W-1:0]   j_ff;
   logic [rc5_pkg::BLOCK_W-1:0]    in_blk_ff;
   logic                           last_ff;

   // round key banks: even and odd key of each round
   logic [W-1:0]                   key_even_mem [DEPTH];
   logic [W-1:0]                   key_odd_mem  [DEPTH];
   logic [W-1:0]                   key_even_ff;
   logic [W-1:0]                   key_odd_ff;

   // result register
   logic                           rsp_valid_ff;
   logic [W-1:0]                   rsp_a_ff;
   logic [W-1:0]                   rsp_b_ff;
   logic                           rsp_last_ff;

   logic [W-1:0] word_a;
   logic [W-1:0] word_b;
   logic [W-1:0] s_src;
   logic [W-1:0] s_new;
   logic [W-1:0] l_sum;
   logic [W-1:0] l_new;
   logic [W-1:0] enc_a;
   logic [W-1:0] enc_b;
   logic [W-1:0] dec_a;
   logic [W-1:0] dec_b;
   logic [W-1:0] step_a;
   logic [W-1:0] step_b;
   logic [W-1:0] base_a;
   logic [W-1:0] base_b;
   logic [W-1:0] res_a;
   logic [W-1:0] res_b;
   logic         deliver;
   logic         out_free;
   logic         cfg_kick;
   logic         crypt_op;

   assign word_a = req_tdata[W-1:0];
   assign word_b = req_tdata[2*W-1:W];

   // a key or iv write restarts the schedule
   assign cfg_kick = csr_wr_en && (csr_index != rc5_pkg::CSR_DIRECTION);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign status   = '{cfg_kick: cfg_kick, decrypt: decrypt_ff, out_free: out_free};

   // key schedule mixing step
   always_comb begin
      s_src = cmd.first_pass ? acc_ff : (key_wr_index[0] ? key_odd_ff : key_even_ff);
      s_new = rc5_pkg::rotl32(s_src + a_ff + b_ff, rc5_pkg::SCHED_ROT);
      l_sum = s_new + b_ff;
      l_new = rc5_pkg::rotl32(lw_ff[j_ff] + l_sum, l_sum[rc5_pkg::ROT_W-1:0]);
   end

   // one full round, either direction
   always_comb begin
      enc_a = rc5_pkg::rotl32(a_ff ^ b_ff, b_ff[rc5_pkg::ROT_W-1:0]) + key_even_ff;
      enc_b = rc5_pkg::rotl32(b_ff ^ enc_a, enc_a[rc5_pkg::ROT_W-1:0]) + key_odd_ff;
      dec_b = rc5_pkg::rotr32(b_ff - key_odd_ff, a_ff[rc5_pkg::ROT_W-1:0]) ^ a_ff;
      dec_a = rc5_pkg::rotr32(a_ff - key_even_ff, dec_b[rc5_pkg::ROT_W-1:0]) ^ dec_b;
   end

   always_comb begin
      crypt_op = 1'b1;
      unique case (cmd.op)
         rc5_pkg::OP_KEY_ADD: begin
            step_a = a_ff + key_even_ff;
            step_b = b_ff + key_odd_ff;
         end
         rc5_pkg::OP_ENC_ROUND: begin
            step_a = enc_a;
            step_b = enc_b;
         end
         rc5_pkg::OP_DEC_ROUND: begin
            step_a = dec_a;
            step_b = dec_b;
         end
         rc5_pkg::OP_KEY_SUB: begin
            step_a = a_ff - key_even_ff;
            step_b = b_ff - key_odd_ff;
         end
         default: begin
            crypt_op = 1'b0;
            step_a   = a_ff;
            step_b   = b_ff;
         end
      endcase
   end

   // result: fresh from the last step or held while the output was busy
   assign deliver = cmd.deliver_step || cmd.deliver_held;
   assign base_a  = cmd.deliver_held ? a_ff : step_a;
   assign base_b  = cmd.deliver_held ? b_ff : step_b;
   assign res_a   = decrypt_ff ? (base_a ^ chain_ff[W-1:0])   : base_a;
   assign res_b   = decrypt_ff ? (base_b ^ chain_ff[2*W-1:W]) : base_b;

   // csr registers, chain and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         iv_ff        <= '0;
         decrypt_ff   <= 1'b0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               rc5_pkg::CSR_KEY_LOW:     key_low_ff  <= csr_wdata;
               rc5_pkg::CSR_KEY_HIGH:    key_high_ff <= csr_wdata;
               rc5_pkg::CSR_INIT_VECTOR: iv_ff       <= csr_wdata;
               rc5_pkg::CSR_DIRECTION:   decrypt_ff  <= csr_wdata[0];
               default:                  decrypt_ff  <= decrypt_ff;
            endcase
         end
         if (cmd.op == rc5_pkg::OP_SCHED_INIT) begin
            chain_ff <= iv_ff;
         end else if (deliver) begin
            chain_ff <= decrypt_ff ? in_blk_ff : {res_b, res_a};
         end
         if (deliver) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working words and schedule state
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         rc5_pkg::OP_LOAD: begin
            a_ff      <= decrypt_ff ? word_a : (word_a ^ chain_ff[W-1:0]);
            b_ff      <= decrypt_ff ? word_b : (word_b ^ chain_ff[2*W-1:W]);
            in_blk_ff <= req_tdata;
            last_ff   <= req_tlast;
         end
         rc5_pkg::OP_SCHED_INIT: begin
            a_ff     <= '0;
            b_ff     <= '0;
            acc_ff   <= rc5_pkg::MAGIC_P;
            j_ff     <= '0;
            lw_ff[0] <= key_low_ff[W-1:0];
            lw_ff[1] <= key_low_ff[2*W-1:W];
            lw_ff[2] <= key_high_ff[W-1:0];
            lw_ff[3] <= key_high_ff[2*W-1:W];
         end
         rc5_pkg::OP_SCHED_STEP: begin
            a_ff        <= s_new;
            b_ff        <= l_new;
            lw_ff[j_ff] <= l_new;
            j_ff        <= j_ff + 1'b1;
            acc_ff      <= acc_ff + rc5_pkg::MAGIC_Q;
         end
         default: begin
            if (crypt_op) begin
               a_ff <= step_a;
               b_ff <= step_b;
            end
         end
      endcase
      if (deliver) begin
         rsp_a_ff    <= res_a;
         rsp_b_ff    <= res_b;
         rsp_last_ff <= last_ff;
      end
   end

   // round key memory: one write per schedule step, registered read
   always_ff @(posedge clock) begin
      if (cmd.op == rc5_pkg::OP_SCHED_STEP) begin
         if (key_wr_index[0]) begin
            key_odd_mem[key_wr_index[IW-1:1]] <= s_new;
         end else begin
            key_even_mem[key_wr_index[IW-1:1]] <= s_new;
         end
      end
      key_even_ff <= key_even_mem[key_rd_addr];
      key_odd_ff  <= key_odd_mem[key_rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_b_ff, rsp_a_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      deliver |-> out_free)
      else $error("result register overwritten while pending");

   // in encrypt mode the chain follows the ciphertext just delivered
   a_enc_chain: assert property (@(posedge clock) disable iff (reset)
      (deliver && !decrypt_ff) |=> (chain_ff == {rsp_b_ff, rsp_a_ff}))
      else $error("chain does not match delivered ciphertext");

   // schedule and block processing never overlap
   a_sched_excl: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rc5_pkg::OP_SCHED_STEP) |-> !deliver)
      else $error("result delivered during key schedule");

endmodule

`default_nettype wire

[src/rc5_cbc_block_cipher.sv]
// A block accepted on req runs a key add and the full rounds (decrypt: rounds,
// then a key subtract), one step per cycle, into the result register; the next
// block waits until that result is delivered. A key or iv write runs the key
// schedule, an init step and then the mixing steps, with req_tready low. Reset
// is synchronous: csr registers, chain and result valid to zero.
// rc5_cbc_block_cipher: top level; joins rc5_ctrl and rc5_dp, uses rc5_pkg.
`default_nettype none

module rc5_cbc_block_cipher #(
   parameter int ROUNDS = rc5_pkg::RC5_ROUNDS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration write port
   input  wire logic                            csr_wr_en,
   input  wire logic [rc5_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rc5_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // input blocks
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [rc5_pkg::BLOCK_W-1:0]     req_tdata,  // word_a[31:0], word_b[63:32]
   input  wire logic                            req_tlast,  // last_block
   // result blocks
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [rc5_pkg::BLOCK_W-1:0]          rsp_tdata,  // result_a[31:0], result_b[63:32]
   output logic                                 rsp_tlast   // result_last
);

   localparam int AW = $clog2(ROUNDS + 1);

   rc5_pkg::dp_cmd_type    cmd;
   rc5_pkg::dp_status_type status;
   logic [AW-1:0]          key_rd_addr;
   logic [AW:0]            key_wr_index;

   // sequencer
   rc5_ctrl #(
      .ROUNDS (ROUNDS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .status       (status),
      .cmd          (cmd),
      .key_rd_addr  (key_rd_addr),
      .key_wr_index (key_wr_index)
   );

   // registers, key memory and round logic
   rc5_dp #(
      .ROUNDS (ROUNDS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .cmd          (cmd),
      .key_rd_addr  (key_rd_addr),
      .key_wr_index (key_wr_index),
      .status       (status)
   );

endmodule

`default_nettype wire
